@@ rtl/ptd_pkg.sv @@
// Shared types, codes and helpers for the periodic task dispatcher.
`default_nettype none
package ptd_pkg;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SCAN = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    localparam logic [9:0] WINDOW_MS = 10'd1000;
    localparam logic [9:0] IDLE_MAX  = 10'd1023;
    localparam int         WALK_CAP  = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  task_index;
        logic [31:0] task_period;
    } t_item;

    typedef struct packed {
        logic        dispatched;
        logic [2:0]  run_task;
        logic [31:0] task_runs;
        logic [31:0] now_ms;
        logic [6:0]  load_pct;
        logic        went_idle;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       tick;
        logic       load;
        logic       rd_en;
        logic [2:0] rd_idx;
        logic       flush;
    } t_cmd;

    typedef struct packed {
        logic [3:0] limit;
    } t_status;

    // x / 10 for x below 1029 as a reciprocal multiply
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return 7'(p >> 11);
    endfunction

endpackage
`default_nettype wire

@@ rtl/ptd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

@@ rtl/ptd_ctrl.sv @@
// Controller: accepts items and sequences the task table walk.
`default_nettype none
module ptd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [1:0]    i_kind,
    input  ptd_pkg::t_status   i_status,
    output ptd_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_idx, n_idx;
    logic       accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_cmd        = '0;
        o_cmd.rd_idx = r_idx[2:0];
        case (r_state)
            ST_IDLE: begin
                o_cmd.tick = accept && (i_kind == ptd_pkg::KIND_TICK);
                o_cmd.load = accept && (i_kind == ptd_pkg::KIND_LOAD);
                if (accept && (i_kind == ptd_pkg::KIND_SCAN)) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (r_idx < i_status.limit) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + 4'd1;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // a scan always ends in a flush cycle
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_kind == ptd_pkg::KIND_SCAN) |=> busy)
        else $error("scan accepted without going busy");
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |=> !busy)
        else $error("flush not followed by idle");
    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> ({1'b0, o_cmd.rd_idx} < i_status.limit))
        else $error("table read past scan limit");

endmodule
`default_nettype wire

@@ rtl/ptd_dp.sv @@
// Datapath: counters, load measurement, task table and result register.
`default_nettype none
module ptd_dp #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ptd_pkg::t_item     i_item,
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_data,
    input  ptd_pkg::t_cmd      i_cmd,
    output ptd_pkg::t_status   o_status,
    output logic               o_valid,
    output ptd_pkg::t_result   o_result
);

    localparam int AW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CAP = (MAX_TASKS < ptd_pkg::WALK_CAP) ? MAX_TASKS : ptd_pkg::WALK_CAP;

    logic [3:0]           r_task_count;
    logic [31:0]          r_ms;
    logic [9:0]           r_idle_cnt, n_idle_cnt;
    logic [9:0]           r_win, n_win;
    logic [6:0]           r_load, n_load;
    logic                 r_mark;
    logic [MAX_TASKS-1:0] r_vld;
    logic                 r_vld_q;
    logic                 r_ev_valid;
    logic [AW-1:0]        r_ev_addr;
    logic                 r_pend_valid;
    logic [2:0]           r_pend_task;
    logic [31:0]          r_pend_runs;
    logic                 r_out_valid, n_out_valid;
    ptd_pkg::t_result     r_out, n_out;

    logic [AW-1:0] rd_addr, ld_addr;
    logic          ld_ok;
    logic [31:0]   due_q, run_q, per_q;
    logic [31:0]   due_eff, run_eff, run_inc, diff;
    logic          hit;
    logic [9:0]    idle_inc, idle_clamp;

    assign rd_addr = AW'(i_cmd.rd_idx);
    assign ld_addr = AW'(i_item.task_index);
    assign ld_ok   = i_cmd.load && (int'(i_item.task_index) < MAX_TASKS);

    assign o_status.limit = (r_task_count > 4'(CAP)) ? 4'(CAP) : r_task_count;

    // entries not valid since reset or load read as zero
    assign due_eff = r_vld_q ? due_q : 32'd0;
    assign run_eff = r_vld_q ? run_q : 32'd0;
    assign run_inc = run_eff + 32'd1;
    assign diff    = r_ms - due_eff;
    assign hit     = r_ev_valid && !diff[31];

    ptd_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_due (
        .i_clk   (i_clk),
        .i_we    (hit),
        .i_waddr (r_ev_addr),
        .i_wdata (r_ms + per_q),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (due_q)
    );

    ptd_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_runs (
        .i_clk   (i_clk),
        .i_we    (hit),
        .i_waddr (r_ev_addr),
        .i_wdata (run_inc),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (run_q)
    );

    ptd_ram #(.WIDTH(32), .DEPTH(MAX_TASKS)) u_period (
        .i_clk   (i_clk),
        .i_we    (ld_ok),
        .i_waddr (ld_addr),
        .i_wdata (i_item.task_period),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (per_q)
    );

    // tick: idle accounting and window close
    always_comb begin
        idle_inc = r_idle_cnt;
        if (r_mark && (r_idle_cnt != ptd_pkg::IDLE_MAX)) begin
            idle_inc = r_idle_cnt + 10'd1;
        end
        idle_clamp = (idle_inc > ptd_pkg::WINDOW_MS) ? ptd_pkg::WINDOW_MS : idle_inc;
        n_idle_cnt = idle_inc;
        n_win      = r_win + 10'd1;
        n_load     = r_load;
        if (r_win == ptd_pkg::WINDOW_MS - 10'd1) begin
            n_win      = '0;
            n_idle_cnt = '0;
            n_load     = ptd_pkg::div10(ptd_pkg::WINDOW_MS - idle_clamp);
        end
    end

    // result selection: a pending dispatch goes out once the next one or the end is known
    always_comb begin
        n_out_valid      = 1'b0;
        n_out            = '0;
        n_out.now_ms     = r_ms;
        n_out.load_pct   = r_load;
        n_out.dispatched = 1'b1;
        n_out.run_task   = r_pend_task;
        n_out.task_runs  = r_pend_runs;
        if (i_cmd.flush) begin
            n_out_valid = 1'b1;
            n_out.last  = 1'b1;
            if (!r_pend_valid) begin
                n_out.dispatched = 1'b0;
                n_out.run_task   = '0;
                n_out.task_runs  = '0;
                n_out.went_idle  = 1'b1;
            end
        end else if (hit && r_pend_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            r_ms         <= '0;
            r_idle_cnt   <= '0;
            r_win        <= '0;
            r_load       <= '0;
            r_mark       <= 1'b0;
            r_vld        <= '0;
            r_ev_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_task_count <= i_cfg_data;
            end
            if (i_cmd.tick) begin
                r_ms       <= r_ms + 32'd1;
                r_idle_cnt <= n_idle_cnt;
                r_win      <= n_win;
                r_load     <= n_load;
                r_mark     <= 1'b0;
            end else if (i_cmd.flush && !r_pend_valid) begin
                r_mark <= 1'b1;
            end
            if (ld_ok) begin
                r_vld[ld_addr] <= 1'b0;
            end else if (hit) begin
                r_vld[r_ev_addr] <= 1'b1;
            end
            r_ev_valid <= i_cmd.rd_en;
            if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end else if (hit) begin
                r_pend_valid <= 1'b1;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_vld_q <= r_vld[rd_addr];
        end
        r_ev_addr <= rd_addr;
        if (hit) begin
            r_pend_task <= 3'(r_ev_addr);
            r_pend_runs <= run_inc;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_flush_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> r_out_valid && r_out.last)
        else $error("flush did not produce a final result");
    a_idle_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.went_idle |-> r_out.last && !r_out.dispatched)
        else $error("idle result malformed");
    a_hit_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> r_pend_valid)
        else $error("due task not held as pending");
    a_idle_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.went_idle |-> r_mark)
        else $error("idle result without idle mark");

endmodule
`default_nettype wire

@@ rtl/periodic_task_dispatcher_with_load.sv @@
// Top level of the periodic task dispatcher with processor load measurement.
// Tick and load items complete at their accept edge; busy stays low and they give no transfer.
// A scan holds busy while it walks limit = min(task_count, MAX_TASKS, 8) table entries, one
// a cycle, and then flushes; the next item is taken only once busy has dropped again.
// Results come at most one a cycle, the final one registered after the flush; no stall.
// Synchronous active-low reset clears counters, config and per-entry valid bits (counts read zero).
`default_nettype none
module periodic_task_dispatcher_with_load #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  ptd_pkg::t_item   i_item,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_valid,
    output ptd_pkg::t_result o_result
);

    // command and status between the sequencer and the datapath
    ptd_pkg::t_cmd    cmd;
    ptd_pkg::t_status status;

    // Sequencer: accept items, walk the table one entry a cycle, then flush
    // the held dispatch (or the idle report) with the last flag.
    ptd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_kind   (i_item.kind),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath: millisecond and idle counters, task tables in RAM, and a
    // one-deep pending stage so each transfer knows whether it is the last.
    ptd_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // every result transfer is either a dispatch or an idle report, never both
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.dispatched != o_result.went_idle))
        else $error("result neither or both dispatch and idle");
    // hold the scan in progress: no result strobes while a scan has not started
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a scan in progress");
    // drop nothing: a final transfer leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.last |-> !busy)
        else $error("final result while still busy");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the periodic task dispatcher with load measurement.
`timescale 1ns / 1ps
module tb_top;

    // Kind code that the block must ignore; the package names only the used ones.
    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         TABLE_SIZE    = 8;
    // Quiet cycles before a register write.
    localparam int         SETTLE_CYCLES = 12;
    localparam int         DRAIN_CYCLES  = 40;

    // One entry of the stimulus queue: either an item transfer or a register write.
    typedef struct {
        bit             is_cfg;
        logic [3:0]     cfg_val;
        ptd_pkg::t_item item;
        int unsigned    gap;
    } t_stim;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    ptd_pkg::t_item   i_item     = '0;
    logic             i_cfg_we   = 1'b0;
    logic [3:0]       i_cfg_data = 4'd0;
    logic             o_valid;
    ptd_pkg::t_result o_result;

    t_stim            stim_q[$];
    ptd_pkg::t_result pending_dispatches[$];
    int               err_count    = 0;

    // Shadow of the block state, advanced at each accepted transfer.
    logic [31:0] now_ms_m    = '0;
    logic [9:0]  idle_ms     = '0;
    logic [9:0]  window_ms   = '0;
    logic [6:0]  load_pct_m  = '0;
    logic        idle_flag   = 1'b0;
    logic [31:0] due_at     [TABLE_SIZE];
    logic [31:0] run_tally  [TABLE_SIZE];
    logic [31:0] period_tab [TABLE_SIZE];
    logic [3:0]  active_tasks = '0;

    periodic_task_dispatcher_with_load dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Advance the shadow state by one accepted item and queue the results it causes.
    task automatic predict_dispatch(input ptd_pkg::t_item it);
        int               walk;
        int               clamp;
        logic [31:0]      diff;
        ptd_pkg::t_result held;
        bit               have_held;
        have_held = 1'b0;
        held      = '0;
        case (it.kind)
            ptd_pkg::KIND_TICK: begin
                now_ms_m = now_ms_m + 32'd1;
                if (idle_flag) begin
                    if (idle_ms < ptd_pkg::IDLE_MAX) idle_ms = idle_ms + 10'd1;
                    idle_flag = 1'b0;
                end
                window_ms = window_ms + 10'd1;
                if (window_ms >= ptd_pkg::WINDOW_MS) begin
                    // close the window: clamp idle time and turn it into a busy percentage
                    clamp      = (idle_ms > ptd_pkg::WINDOW_MS) ?
                                 int'(ptd_pkg::WINDOW_MS) : int'(idle_ms);
                    load_pct_m = 7'((1000 - clamp) / 10);
                    window_ms  = '0;
                    idle_ms    = '0;
                end
            end
            ptd_pkg::KIND_LOAD: begin
                period_tab[it.task_index] = it.task_period;
                due_at[it.task_index]     = '0;
                run_tally[it.task_index]  = '0;
            end
            ptd_pkg::KIND_SCAN: begin
                walk = (active_tasks > TABLE_SIZE) ? TABLE_SIZE : int'(active_tasks);
                for (int i = 0; i < walk; i++) begin
                    // wrap-safe compare: due when the difference is not negative
                    diff = now_ms_m - due_at[i];
                    if (!diff[31]) begin
                        due_at[i]    = now_ms_m + period_tab[i];
                        run_tally[i] = run_tally[i] + 32'd1;
                        // hold each result back one step so the final one can be marked
                        if (have_held) pending_dispatches.push_back(held);
                        held            = '0;
                        held.dispatched = 1'b1;
                        held.run_task   = 3'(i);
                        held.task_runs  = run_tally[i];
                        held.now_ms     = now_ms_m;
                        held.load_pct   = load_pct_m;
                        have_held       = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    pending_dispatches.push_back(held);
                end else begin
                    // nothing due: report idle and arm the idle mark for the next tick
                    idle_flag      = 1'b1;
                    held.now_ms    = now_ms_m;
                    held.load_pct  = load_pct_m;
                    held.went_idle = 1'b1;
                    held.last      = 1'b1;
                    pending_dispatches.push_back(held);
                end
            end
            default: begin
                // unused kind: drop it, no state change and no result
            end
        endcase
    endtask

    // Driver: present queued items on start, and write the register only when quiet.
    always @(posedge i_clk) begin : drive
        bit             taken;
        bit             hold;
        bit             next_start;
        bit             next_we;
        ptd_pkg::t_item next_item;
        logic [3:0]     next_data;
        int unsigned    gap_count;
        int unsigned    settle;
        if (!i_rst_n) begin
            start      <= 1'b0;
            i_cfg_we   <= 1'b0;
            gap_count  = 0;
            settle     = 0;
        end else begin
            taken = start && !busy;
            if (taken) predict_dispatch(i_item);
            hold       = start && !taken;
            next_start = hold;
            next_item  = i_item;
            next_we    = 1'b0;
            next_data  = i_cfg_data;
            // count edges with nothing held on start and nothing still to come out
            if (!hold && pending_dispatches.size() == 0) begin
                if (settle < 1000) settle++;
            end else begin
                settle = 0;
            end
            if (!hold && stim_q.size() != 0) begin
                if (stim_q[0].is_cfg) begin
                    if (settle >= SETTLE_CYCLES) begin
                        next_we      = 1'b1;
                        next_data    = stim_q[0].cfg_val;
                        active_tasks = stim_q[0].cfg_val;
                        void'(stim_q.pop_front());
                        settle = 0;
                    end
                end else if (gap_count < stim_q[0].gap) begin
                    gap_count++;
                end else begin
                    next_start = 1'b1;
                    next_item  = stim_q[0].item;
                    void'(stim_q.pop_front());
                    gap_count = 0;
                end
            end
            start      <= next_start;
            i_item     <= next_item;
            i_cfg_we   <= next_we;
            i_cfg_data <= next_data;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    // Monitor: every strobed result is a transfer; match it against the oldest expectation.
    always @(posedge i_clk) begin : watch
        ptd_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_dispatches.size() == 0) begin
                $error("unexpected result: now_ms %0d run_task %0d",
                       o_result.now_ms, o_result.run_task);
                err_count++;
            end else begin
                want = pending_dispatches.pop_front();
                check_field("dispatched", 32'(want.dispatched), 32'(o_result.dispatched));
                check_field("run_task",   32'(want.run_task),   32'(o_result.run_task));
                check_field("task_runs",  want.task_runs,       o_result.task_runs);
                check_field("now_ms",     want.now_ms,          o_result.now_ms);
                check_field("load_pct",   32'(want.load_pct),   32'(o_result.load_pct));
                check_field("went_idle",  32'(want.went_idle),  32'(o_result.went_idle));
                check_field("last",       32'(want.last),       32'(o_result.last));
            end
        end
    end

    task automatic add_item(input logic [1:0] kind, input logic [2:0] idx,
                            input logic [31:0] period, input int unsigned gap);
        t_stim s;
        s.is_cfg           = 1'b0;
        s.cfg_val          = '0;
        s.item.kind        = kind;
        s.item.task_index  = idx;
        s.item.task_period = period;
        s.gap              = gap;
        stim_q.push_back(s);
    endtask

    task automatic add_cfg(input logic [3:0] val);
        t_stim s;
        s.is_cfg  = 1'b1;
        s.cfg_val = val;
        s.item    = '0;
        s.gap     = 0;
        stim_q.push_back(s);
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small periods keep tasks firing; others are random or probe the compare's sign boundary.
    function automatic logic [31:0] pick_period();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 32'($urandom_range(0, 12));
        if (r < 75) return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h8000_0001;
            3:       return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    initial begin : stimulus
        int          made;
        int          r;
        int unsigned g;
        int unsigned n;
        bit          calm;
        logic [3:0]  cfg_val;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            due_at[i]     = '0;
            run_tally[i]  = '0;
            period_tab[i] = '0;
        end

        // Directed: empty walk, idle mark consumed and held, ignored kind, every entry loaded.
        add_cfg(4'd0);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_TICK, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_SCAN, 3'd7, 32'hFFFF_FFFF, 0);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 2);
        add_item(ptd_pkg::KIND_TICK, 3'd7, 32'hFFFF_FFFF, 0);
        add_item(KIND_UNUSED, 3'd7, 32'hFFFF_FFFF, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd1, 32'd1, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd2, 32'd2, 1);
        add_item(ptd_pkg::KIND_LOAD, 3'd3, 32'd5, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd4, 32'hFFFF_FFFF, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd5, 32'h8000_0000, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd6, 32'h7FFF_FFFF, 0);
        add_item(ptd_pkg::KIND_LOAD, 3'd7, 32'd3, 0);
        // full table: all entries due at once, then the short periods and the wrapping one
        add_cfg(4'd8);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_TICK, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_TICK, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 1);
        // count above the table size walks the whole table only
        add_cfg(4'd15);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_TICK, 3'd0, 32'd0, 0);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 0);
        add_cfg(4'd1);
        add_item(ptd_pkg::KIND_SCAN, 3'd0, 32'd0, 0);

        // Random phases, each under its own task count.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       cfg_val = 4'd8;
                1:       cfg_val = 4'd0;
                2:       cfg_val = 4'd15;
                3:       cfg_val = 4'd3;
                default: cfg_val = 4'($urandom_range(0, 15));
            endcase
            add_cfg(cfg_val);
            calm = ($urandom_range(0, 3) == 0);
            made = 0;
            while (made < 42) begin
                r = $urandom_range(0, 99);
                g = calm ? 0 : pick_gap();
                if (r < 30) begin
                    add_item(ptd_pkg::KIND_TICK, 3'($urandom), $urandom, g);
                    made++;
                end else if (r < 36) begin
                    // burst of ticks lets longer periods come due
                    n = $urandom_range(5, 40);
                    for (int unsigned k = 0; k < n; k++)
                        add_item(ptd_pkg::KIND_TICK, 3'($urandom), $urandom, 0);
                    made += n;
                end else if (r < 74) begin
                    add_item(ptd_pkg::KIND_SCAN, 3'($urandom), $urandom, g);
                    made++;
                end else if (r < 95) begin
                    add_item(ptd_pkg::KIND_LOAD, 3'($urandom), pick_period(), g);
                    made++;
                end else begin
                    add_item(KIND_UNUSED, 3'($urandom), $urandom, g);
                end
            end
        end

        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every item is issued and every dispatch has come out, then drain.
        while (stim_q.size() != 0 || start || pending_dispatches.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_dispatches.size() != 0) begin
            $error("%0d expected results never arrived", pending_dispatches.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("[periodic_task_dispatcher_with_load] OK");
        end else begin
            $display("[periodic_task_dispatcher_with_load] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("[periodic_task_dispatcher_with_load] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ptd_pkg.sv
rtl/ptd_ram.sv
rtl/ptd_ctrl.sv
rtl/ptd_dp.sv
rtl/periodic_task_dispatcher_with_load.sv
tb/sv/tb_top.sv
